FILE: src/rwhf_pkg.sv
// ----------------------------------------------------------------------------
// rwhf_pkg
// Shared widths, register indexes, routing codes and types for the
// read/write hazard filter queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rwhf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_WIDTH  = 48;
  localparam int TAG_WIDTH   = 16;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ADDR_WIDTH;
  localparam int SEL_W      = 6;
  localparam int MODE_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROUTE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_BIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE = 3'd4;

  localparam logic [MODE_W-1:0] MODE_ALL_CACHE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALL_SCHED = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WINDOW    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BIT       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WIN_BIT   = 3'd4;

  // Input beat layout (tdata), lowest bit first
  localparam int IN_USE_RD       = 0;
  localparam int IN_RD_ADDR_LSB  = 1;
  localparam int IN_RD_TAG_LSB   = IN_RD_ADDR_LSB + ADDR_WIDTH;
  localparam int IN_USE_WR       = IN_RD_TAG_LSB + TAG_WIDTH;
  localparam int IN_WR_ADDR_LSB  = IN_USE_WR + 1;
  localparam int IN_WR_TAG_LSB   = IN_WR_ADDR_LSB + ADDR_WIDTH;
  localparam int IN_BITS         = IN_WR_TAG_LSB + TAG_WIDTH;
  localparam int IN_DATA_W       = ((IN_BITS + 7) / 8) * 8;

  // Output beat layout (tdata), lowest bit first
  localparam int OUT_RD_ACC      = 0;
  localparam int OUT_WR_ACC      = 1;
  localparam int OUT_RD_VALID    = 2;
  localparam int OUT_RD_ADDR_LSB = 3;
  localparam int OUT_RD_TAG_LSB  = OUT_RD_ADDR_LSB + ADDR_WIDTH;
  localparam int OUT_RD_CACHE    = OUT_RD_TAG_LSB + TAG_WIDTH;
  localparam int OUT_WR_VALID    = OUT_RD_CACHE + 1;
  localparam int OUT_WR_ADDR_LSB = OUT_WR_VALID + 1;
  localparam int OUT_WR_TAG_LSB  = OUT_WR_ADDR_LSB + ADDR_WIDTH;
  localparam int OUT_WR_CACHE    = OUT_WR_TAG_LSB + TAG_WIDTH;
  localparam int OUT_BOTH_EMPTY  = OUT_WR_CACHE + 1;
  localparam int OUT_BITS        = OUT_BOTH_EMPTY + 1;
  localparam int OUT_DATA_W      = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [MODE_W-1:0]     route_mode;
    logic [ADDR_WIDTH-1:0] window_low;
    logic [ADDR_WIDTH-1:0] window_high;
    logic [SEL_W-1:0]      select_bit;
    logic                  cache_enable;
  } route_cfg_t;

  typedef struct packed {
    logic                  hit;
    logic                  full;
    logic                  empty;
    logic [ADDR_WIDTH-1:0] head_addr;
    logic [TAG_WIDTH-1:0]  head_tag;
  } queue_stat_t;

endpackage

`default_nettype wire

FILE: src/rwhf_lane.sv
// ----------------------------------------------------------------------------
// rwhf_lane
// One queue entry: holds an address and tag and compares the stored address
// against a probe address.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhf_lane (
  input  wire                           clk,
  input  wire                           we,
  input  wire [rwhf_pkg::ADDR_WIDTH-1:0] wr_addr,
  input  wire [rwhf_pkg::TAG_WIDTH-1:0]  wr_tag,
  input  wire                           occupied,
  input  wire [rwhf_pkg::ADDR_WIDTH-1:0] probe_addr,
  output logic [rwhf_pkg::ADDR_WIDTH-1:0] entry_addr,
  output logic [rwhf_pkg::TAG_WIDTH-1:0]  entry_tag,
  output logic                          hit
);
  import rwhf_pkg::*;

  always_ff @(posedge clk) begin
    if (we) begin
      entry_addr <= wr_addr;
      entry_tag  <= wr_tag;
    end
  end

  assign hit = occupied && (entry_addr == probe_addr);

endmodule

`default_nettype wire

FILE: src/rwhf_queue.sv
// ----------------------------------------------------------------------------
// rwhf_queue
// Circular FIFO built from compare lanes. Every occupied lane checks the
// probe address in parallel and the hits are merged into one flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhf_queue (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            push,
  input  wire [rwhf_pkg::ADDR_WIDTH-1:0] push_addr,
  input  wire [rwhf_pkg::TAG_WIDTH-1:0]  push_tag,
  input  wire                            pop,
  input  wire [rwhf_pkg::ADDR_WIDTH-1:0] probe_addr,
  output rwhf_pkg::queue_stat_t          stat
);
  import rwhf_pkg::*;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail;
  logic             do_pop;

  logic [QUEUE_DEPTH-1:0] lane_hit;
  logic [QUEUE_DEPTH-1:0] lane_occ;
  logic [QUEUE_DEPTH-1:0] lane_we;
  logic [ADDR_WIDTH-1:0]  lane_addr [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0]   lane_tag  [QUEUE_DEPTH];

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign do_pop     = pop && !stat.empty;

  // Tail wraps once at most since head is below the depth and count is at most the depth.
  assign tail_sum = {1'b0, head} + SUM_W'(count);
  assign tail = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

  assign head_next = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);

  always_comb begin
    count_next = count;
    if (push && !do_pop) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (do_pop) begin
        head <= head_next;
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_lane
    logic [SUM_W-1:0] ring_ofs;

    // Distance from the head going forward around the ring.
    assign ring_ofs = (PTR_W'(i) >= head) ?
                      SUM_W'(i) - {1'b0, head} :
                      SUM_W'(i) + SUM_W'(QUEUE_DEPTH) - {1'b0, head};
    assign lane_occ[i] = ring_ofs < SUM_W'(count);
    assign lane_we[i]  = push && (tail == PTR_W'(i));

    rwhf_lane u_lane (
      .clk        (clk),
      .we         (lane_we[i]),
      .wr_addr    (push_addr),
      .wr_tag     (push_tag),
      .occupied   (lane_occ[i]),
      .probe_addr (probe_addr),
      .entry_addr (lane_addr[i]),
      .entry_tag  (lane_tag[i]),
      .hit        (lane_hit[i])
    );
  end

  assign stat.hit       = |lane_hit;
  assign stat.head_addr = lane_addr[head];
  assign stat.head_tag  = lane_tag[head];

endmodule

`default_nettype wire

FILE: src/rwhf_route.sv
// ----------------------------------------------------------------------------
// rwhf_route
// Decides whether a queue head goes to the cache or to the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhf_route (
  input  rwhf_pkg::route_cfg_t           cfg,
  input  wire [rwhf_pkg::ADDR_WIDTH-1:0] addr,
  output logic                           to_cache
);
  import rwhf_pkg::*;

  logic                  in_win;
  logic                  bit_zero;
  logic                  sel_ok;
  logic [ADDR_WIDTH-1:0] shifted;
  logic                  mode_hit;

  assign in_win = (addr >= cfg.window_low) && (addr <= cfg.window_high);

  // A selector of zero or past the address width reads as a zero bit.
  assign sel_ok   = (cfg.select_bit != '0) &&
                    ({1'b0, cfg.select_bit} <= (SEL_W + 1)'(ADDR_WIDTH));
  assign shifted  = addr >> (cfg.select_bit - SEL_W'(1));
  assign bit_zero = sel_ok ? !shifted[0] : 1'b1;

  always_comb begin
    unique case (cfg.route_mode)
      MODE_ALL_CACHE: mode_hit = 1'b1;
      MODE_WINDOW:    mode_hit = in_win;
      MODE_BIT:       mode_hit = bit_zero;
      MODE_WIN_BIT:   mode_hit = in_win && bit_zero;
      default:        mode_hit = 1'b0;
    endcase
  end

  assign to_cache = mode_hit && cfg.cache_enable;

endmodule

`default_nettype wire

FILE: src/rw_hazard_filter_queue_unit.sv
// ----------------------------------------------------------------------------
// rw_hazard_filter_queue_unit
// Read and write queues with a cross address hazard check and head routing.
//
// Usage:
// - Input stream (s_*): one beat is either an offer (tuser 0) of a read
//   and/or a write, or a pop (tuser 1) of the read and/or write head.
//   An offered read enters its queue when there is room and no queued
//   write has the same address; the offered write is then checked against
//   the read queue including a read just taken.
// - Output stream (m_*): exactly one beat per input beat with the accept
//   flags, both queue heads with their cache route flags, and a flag that
//   says both queues are empty.
// - Configuration: cfg_we/cfg_index/cfg_data; the user must write them
//   only while idle, the block does not enforce this. Timing: the queues
//   and lane entries update at the accept edge; the head select and route
//   compare land in the output register at the next edge.
// - Stall: while an item is pending or an output beat waits, s_tready
//   stays low and nothing is lost; the output beat holds until taken.
// - Reset (rst, synchronous): both queues empty, registers at defaults
//   (scheduler routing, window of address 0 only, bit 1, cache enabled).
// ----------------------------------------------------------------------------
`default_nettype none

module rw_hazard_filter_queue_unit (
  input  wire                                   clk,
  input  wire                                   rst,
  // use_rd, rd_addr, rd_tag, use_wr, wr_addr, wr_tag, zero pad
  input  wire [rwhf_pkg::IN_DATA_W-1:0]         s_tdata,
  // cmd
  input  wire                                   s_tuser,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // rd_accepted, wr_accepted, rd_head_valid, rd_head_addr, rd_head_tag,
  // rd_head_to_cache, wr_head_valid, wr_head_addr, wr_head_tag,
  // wr_head_to_cache, both_empty, zero pad
  output logic [rwhf_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  input  wire                                   cfg_we,
  input  wire [rwhf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [rwhf_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import rwhf_pkg::*;

  route_cfg_t  cfg;
  queue_stat_t rq_stat;
  queue_stat_t wq_stat;

  logic                  s_fire;
  logic                  cmd;
  logic                  use_rd;
  logic                  use_wr;
  logic [ADDR_WIDTH-1:0] rd_addr;
  logic [TAG_WIDTH-1:0]  rd_tag;
  logic [ADDR_WIDTH-1:0] wr_addr;
  logic [TAG_WIDTH-1:0]  wr_tag;
  logic                  rd_ok;
  logic                  wr_ok;

  logic                  pend;
  logic                  acc_rd;
  logic                  acc_wr;
  logic                  rd_cache;
  logic                  wr_cache;
  logic [OUT_BITS-1:0]   out_bits;

  assign cmd     = s_tuser;
  assign use_rd  = s_tdata[IN_USE_RD];
  assign rd_addr = s_tdata[IN_RD_ADDR_LSB +: ADDR_WIDTH];
  assign rd_tag  = s_tdata[IN_RD_TAG_LSB +: TAG_WIDTH];
  assign use_wr  = s_tdata[IN_USE_WR];
  assign wr_addr = s_tdata[IN_WR_ADDR_LSB +: ADDR_WIDTH];
  assign wr_tag  = s_tdata[IN_WR_TAG_LSB +: TAG_WIDTH];

  assign s_tready = !pend && (!m_tvalid || m_tready);
  assign s_fire   = s_tvalid && s_tready;

  // The write also collides with a read being enqueued in the same beat.
  assign rd_ok = !cmd && use_rd && !rq_stat.full && !wq_stat.hit;
  assign wr_ok = !cmd && use_wr && !wq_stat.full &&
                 !(rq_stat.hit || (rd_ok && (rd_addr == wr_addr)));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.route_mode   <= MODE_ALL_SCHED;
      cfg.window_low   <= '0;
      cfg.window_high  <= '0;
      cfg.select_bit   <= SEL_W'(1);
      cfg.cache_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROUTE_MODE:   cfg.route_mode   <= cfg_data[MODE_W-1:0];
        REG_WINDOW_LOW:   cfg.window_low   <= cfg_data[ADDR_WIDTH-1:0];
        REG_WINDOW_HIGH:  cfg.window_high  <= cfg_data[ADDR_WIDTH-1:0];
        REG_SELECT_BIT:   cfg.select_bit   <= cfg_data[SEL_W-1:0];
        REG_CACHE_ENABLE: cfg.cache_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rwhf_queue u_rd_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_fire && rd_ok),
    .push_addr  (rd_addr),
    .push_tag   (rd_tag),
    .pop        (s_fire && cmd && use_rd),
    .probe_addr (wr_addr),
    .stat       (rq_stat)
  );

  rwhf_queue u_wr_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_fire && wr_ok),
    .push_addr  (wr_addr),
    .push_tag   (wr_tag),
    .pop        (s_fire && cmd && use_wr),
    .probe_addr (rd_addr),
    .stat       (wq_stat)
  );

  rwhf_route u_rd_route (
    .cfg      (cfg),
    .addr     (rq_stat.head_addr),
    .to_cache (rd_cache)
  );

  rwhf_route u_wr_route (
    .cfg      (cfg),
    .addr     (wq_stat.head_addr),
    .to_cache (wr_cache)
  );

  // Second stage: the queues already hold the state after the item.
  always_comb begin
    out_bits = '0;
    out_bits[OUT_RD_ACC] = acc_rd;
    out_bits[OUT_WR_ACC] = acc_wr;
    if (!rq_stat.empty) begin
      out_bits[OUT_RD_VALID] = 1'b1;
      out_bits[OUT_RD_ADDR_LSB +: ADDR_WIDTH] = rq_stat.head_addr;
      out_bits[OUT_RD_TAG_LSB +: TAG_WIDTH]   = rq_stat.head_tag;
      out_bits[OUT_RD_CACHE] = rd_cache;
    end
    if (!wq_stat.empty) begin
      out_bits[OUT_WR_VALID] = 1'b1;
      out_bits[OUT_WR_ADDR_LSB +: ADDR_WIDTH] = wq_stat.head_addr;
      out_bits[OUT_WR_TAG_LSB +: TAG_WIDTH]   = wq_stat.head_tag;
      out_bits[OUT_WR_CACHE] = wr_cache;
    end
    out_bits[OUT_BOTH_EMPTY] = rq_stat.empty && wq_stat.empty;
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      acc_rd <= rd_ok;
      acc_wr <= wr_ok;
    end
    if (pend) begin
      m_tdata <= OUT_DATA_W'(out_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      pend <= s_fire;
      if (pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/rwhf_checker.sv
// ----------------------------------------------------------------------------
// rwhf_checker
// Port level checks for the hazard filter queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhf_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                s_tvalid,
  input wire                                s_tready,
  input wire [rwhf_pkg::OUT_DATA_W-1:0]     m_tdata,
  input wire                                m_tvalid,
  input wire                                m_tready
);
  import rwhf_pkg::*;

  logic s_fire;
  assign s_fire = s_tvalid && s_tready;

  // One item at a time: the input closes right after a beat is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("input accepted while an item is in flight");

  // Every accepted beat is followed by a valid output beat.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    s_fire |-> ##2 m_tvalid)
    else $error("result beat missing after accepted input");

  a_both_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_BOTH_EMPTY] |->
      !m_tdata[OUT_RD_VALID] && !m_tdata[OUT_WR_VALID])
    else $error("both-empty flag set while a queue head is valid");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OUT_RD_VALID] |->
      m_tdata[OUT_RD_ADDR_LSB +: ADDR_WIDTH] == '0 && !m_tdata[OUT_RD_CACHE])
    else $error("empty read head carries nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

endmodule

bind rw_hazard_filter_queue_unit rwhf_checker u_rwhf_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the read/write hazard filter queue. A directed
// table opens the run, then ten routing settings each get a burst of random
// offers and pops. Every output beat is checked against a shadow copy of both
// queues and of the routing registers. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  import rwhf_pkg::*;

  typedef enum bit {CMD_OFFER = 1'b0, CMD_POP = 1'b1} cmd_e;

  // Input beat, lowest field last.
  typedef struct packed {
    logic [IN_DATA_W-IN_BITS-1:0] pad;
    logic [TAG_WIDTH-1:0]         wr_tag;
    logic [ADDR_WIDTH-1:0]        wr_addr;
    logic                         use_wr;
    logic [TAG_WIDTH-1:0]         rd_tag;
    logic [ADDR_WIDTH-1:0]        rd_addr;
    logic                         use_rd;
  } txn_pair_t;

  // Output beat, lowest field last.
  typedef struct packed {
    logic [OUT_DATA_W-OUT_BITS-1:0] pad;
    logic                           both_empty;
    logic                           wr_cache;
    logic [TAG_WIDTH-1:0]           wr_tag;
    logic [ADDR_WIDTH-1:0]          wr_addr;
    logic                           wr_valid;
    logic                           rd_cache;
    logic [TAG_WIDTH-1:0]           rd_tag;
    logic [ADDR_WIDTH-1:0]          rd_addr;
    logic                           rd_valid;
    logic                           wr_acc;
    logic                           rd_acc;
  } heads_beat_t;

  typedef struct packed {
    cmd_e        cmd;
    txn_pair_t   pair;
    bit          typed;
    heads_beat_t want;
  } step_row_t;

  localparam int RDQ = 0;
  localparam int WRQ = 1;
  localparam int POOL_SIZE = 10;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 128;
  localparam logic [ADDR_WIDTH-1:0] ADDR_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // use_rd, rd_addr, rd_tag, use_wr, wr_addr, wr_tag, pad
  logic                  s_tuser = 1'b0;  // cmd
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;         // rd_acc, wr_acc, rd head, wr head, both_empty, pad
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rw_hazard_filter_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of both queues and of the routing registers.
  bit [ADDR_WIDTH-1:0] q_addr [2][QUEUE_DEPTH];
  bit [TAG_WIDTH-1:0]  q_tag  [2][QUEUE_DEPTH];
  int unsigned         q_fill [2];
  int unsigned         q_head [2];
  route_cfg_t          route_shadow;

  heads_beat_t         heads_due[$];
  step_row_t           dir_steps[$];
  bit [ADDR_WIDTH-1:0] addr_pool[POOL_SIZE];
  bit                  steady;
  int                  mismatches;
  int                  beats_in;
  int                  beats_out;
  int                  hazard_refusals;
  int                  full_refusals;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic bit [ADDR_WIDTH-1:0] rand_addr();
    bit [63:0] w;
    w = {$urandom(), $urandom()};
    return w[ADDR_WIDTH-1:0];
  endfunction

  function automatic bit to_cache_route(bit [ADDR_WIDTH-1:0] a);
    bit in_win;
    bit bit_zero;
    bit r;
    in_win = a >= route_shadow.window_low && a <= route_shadow.window_high;
    bit_zero = 1'b1;
    // A selector of zero or past the address width reads as a zero bit.
    if (route_shadow.select_bit >= 1 && route_shadow.select_bit <= ADDR_WIDTH)
      bit_zero = !a[route_shadow.select_bit - 1];
    case (route_shadow.route_mode)
      MODE_ALL_CACHE: r = 1'b1;
      MODE_WINDOW:    r = in_win;
      MODE_BIT:       r = bit_zero;
      MODE_WIN_BIT:   r = in_win && bit_zero;
      default:        r = 1'b0;
    endcase
    return r && route_shadow.cache_enable;
  endfunction

  function automatic bit queue_holds(int qi, bit [ADDR_WIDTH-1:0] a);
    for (int unsigned i = 0; i < q_fill[qi]; i++)
      if (q_addr[qi][(q_head[qi] + i) % QUEUE_DEPTH] == a) return 1'b1;
    return 1'b0;
  endfunction

  // Enqueue into queue qi unless it is full or the other queue holds a.
  function automatic bit try_enqueue(int qi, bit [ADDR_WIDTH-1:0] a, bit [TAG_WIDTH-1:0] t);
    int unsigned slot;
    if (q_fill[qi] == QUEUE_DEPTH) begin
      full_refusals++;
      return 1'b0;
    end
    if (queue_holds(1 - qi, a)) begin
      hazard_refusals++;
      return 1'b0;
    end
    slot = (q_head[qi] + q_fill[qi]) % QUEUE_DEPTH;
    q_addr[qi][slot] = a;
    q_tag[qi][slot] = t;
    q_fill[qi]++;
    return 1'b1;
  endfunction

  function automatic void queue_pop(int qi);
    if (q_fill[qi] == 0) return;
    q_head[qi] = (q_head[qi] + 1) % QUEUE_DEPTH;
    q_fill[qi]--;
  endfunction

  function automatic heads_beat_t predict_heads(cmd_e cmd, txn_pair_t p);
    heads_beat_t b;
    b = '0;
    if (cmd == CMD_OFFER) begin
      // The read goes first, so a write to the same address sees it.
      if (p.use_rd) b.rd_acc = try_enqueue(RDQ, p.rd_addr, p.rd_tag);
      if (p.use_wr) b.wr_acc = try_enqueue(WRQ, p.wr_addr, p.wr_tag);
    end else begin
      if (p.use_rd) queue_pop(RDQ);
      if (p.use_wr) queue_pop(WRQ);
    end
    if (q_fill[RDQ] != 0) begin
      b.rd_valid = 1'b1;
      b.rd_addr = q_addr[RDQ][q_head[RDQ]];
      b.rd_tag = q_tag[RDQ][q_head[RDQ]];
      b.rd_cache = to_cache_route(b.rd_addr);
    end
    if (q_fill[WRQ] != 0) begin
      b.wr_valid = 1'b1;
      b.wr_addr = q_addr[WRQ][q_head[WRQ]];
      b.wr_tag = q_tag[WRQ][q_head[WRQ]];
      b.wr_cache = to_cache_route(b.wr_addr);
    end
    b.both_empty = q_fill[RDQ] == 0 && q_fill[WRQ] == 0;
    return b;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  function automatic void check_beat(heads_beat_t got);
    heads_beat_t want;
    string diff;
    if (heads_due.size() == 0) begin
      note_mismatch($sformatf("output beat %h with nothing expected", got));
      return;
    end
    want = heads_due.pop_front();
    diff = "";
    if (got.rd_acc !== want.rd_acc) diff = {diff, " rd_accepted"};
    if (got.wr_acc !== want.wr_acc) diff = {diff, " wr_accepted"};
    if (got.rd_valid !== want.rd_valid) diff = {diff, " rd_head_valid"};
    if (got.rd_addr !== want.rd_addr) diff = {diff, " rd_head_addr"};
    if (got.rd_tag !== want.rd_tag) diff = {diff, " rd_head_tag"};
    if (got.rd_cache !== want.rd_cache) diff = {diff, " rd_head_to_cache"};
    if (got.wr_valid !== want.wr_valid) diff = {diff, " wr_head_valid"};
    if (got.wr_addr !== want.wr_addr) diff = {diff, " wr_head_addr"};
    if (got.wr_tag !== want.wr_tag) diff = {diff, " wr_head_tag"};
    if (got.wr_cache !== want.wr_cache) diff = {diff, " wr_head_to_cache"};
    if (got.both_empty !== want.both_empty) diff = {diff, " both_empty"};
    if (diff != "")
      note_mismatch($sformatf("output beat %0d,%s differ: expected %h, got %h",
                              beats_out, diff, want, got));
  endfunction

  function automatic heads_beat_t beat(logic ra, logic wa, logic rv, logic [ADDR_WIDTH-1:0] radr,
                                       logic [TAG_WIDTH-1:0] rtag, logic rc, logic wv,
                                       logic [ADDR_WIDTH-1:0] wadr, logic [TAG_WIDTH-1:0] wtag,
                                       logic wc, logic done);
    heads_beat_t b;
    b = '0;
    b.rd_acc = ra;
    b.wr_acc = wa;
    b.rd_valid = rv;
    b.rd_addr = radr;
    b.rd_tag = rtag;
    b.rd_cache = rc;
    b.wr_valid = wv;
    b.wr_addr = wadr;
    b.wr_tag = wtag;
    b.wr_cache = wc;
    b.both_empty = done;
    return b;
  endfunction

  function automatic step_row_t offer_row(logic ur, logic [ADDR_WIDTH-1:0] ra,
                                          logic [TAG_WIDTH-1:0] rt, logic uw,
                                          logic [ADDR_WIDTH-1:0] wa, logic [TAG_WIDTH-1:0] wt);
    step_row_t r;
    r = '0;
    r.cmd = CMD_OFFER;
    r.pair.use_rd = ur;
    r.pair.rd_addr = ra;
    r.pair.rd_tag = rt;
    r.pair.use_wr = uw;
    r.pair.wr_addr = wa;
    r.pair.wr_tag = wt;
    return r;
  endfunction

  function automatic step_row_t pop_row(logic ur, logic uw);
    step_row_t r;
    r = offer_row(ur, ADDR_MAX, '1, uw, ADDR_MAX, '1);
    r.cmd = CMD_POP;
    return r;
  endfunction

  function automatic step_row_t with_result(step_row_t r, heads_beat_t w);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic txn_pair_t random_pair();
    txn_pair_t p;
    p = '0;
    p.use_rd = $urandom_range(0, 99) < 80;
    p.use_wr = $urandom_range(0, 99) < 80;
    p.rd_addr = $urandom_range(0, 3) == 0 ? rand_addr() : addr_pool[$urandom_range(0, POOL_SIZE-1)];
    p.wr_addr = $urandom_range(0, 1) == 0 ? rand_addr() : addr_pool[$urandom_range(0, POOL_SIZE-1)];
    p.rd_tag = TAG_WIDTH'($urandom_range(0, 65535));
    p.wr_tag = TAG_WIDTH'($urandom_range(0, 65535));
    return p;
  endfunction

  function automatic route_cfg_t pick_routing(int ph);
    route_cfg_t c;
    bit [ADDR_WIDTH-1:0] a;
    bit [ADDR_WIDTH-1:0] b;
    a = rand_addr();
    b = rand_addr();
    c.window_low = a < b ? a : b;
    c.window_high = a < b ? b : a;
    c.select_bit = SEL_W'($urandom_range(1, ADDR_WIDTH));
    c.cache_enable = 1'b1;
    case (ph)
      0: begin
        c.route_mode = MODE_ALL_CACHE;
        c.window_low = '0;
        c.window_high = ADDR_MAX;
        c.select_bit = 1;
      end
      1: begin
        c.route_mode = MODE_WINDOW;
        c.select_bit = SEL_W'(ADDR_WIDTH);
      end
      2: begin
        // Inverted window and a selector of zero.
        c.route_mode = MODE_BIT;
        c.window_low = ADDR_MAX;
        c.window_high = '0;
        c.select_bit = 0;
      end
      3: c.route_mode = MODE_WIN_BIT;
      4: begin
        c.route_mode = MODE_WIN_BIT;
        c.window_low = c.window_high;
        c.window_high = c.window_low - 1;
        c.select_bit = SEL_W'($urandom_range(ADDR_WIDTH + 1, 63));
      end
      5: begin
        c.route_mode = MODE_WINDOW;
        c.cache_enable = 1'b0;
      end
      6: c.route_mode = 3'd7;
      7: c.route_mode = 3'd5;
      8: c.route_mode = 3'd6;
      default: begin
        c.route_mode = MODE_W'($urandom_range(0, 7));
        c.select_bit = SEL_W'($urandom_range(0, 63));
        c.cache_enable = 1'($urandom_range(0, 1));
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_routing(route_cfg_t c);
    write_reg(REG_ROUTE_MODE, CFG_DATA_W'(c.route_mode));
    write_reg(REG_WINDOW_LOW, c.window_low);
    write_reg(REG_WINDOW_HIGH, c.window_high);
    write_reg(REG_SELECT_BIT, CFG_DATA_W'(c.select_bit));
    write_reg(REG_CACHE_ENABLE, CFG_DATA_W'(c.cache_enable));
    cfg_we <= 1'b0;
    route_shadow = c;
  endtask

  task automatic send_beat(step_row_t r);
    heads_beat_t w;
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.cmd;
    s_tdata <= r.pair;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    w = predict_heads(r.cmd, r.pair);
    heads_due.push_back(r.typed ? r.want : w);
    beats_in++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (heads_due.size() != 0) @(posedge clk);
  endtask

  // Output side: check every beat, idle at random, and once hold off long
  // enough that the input side stalls.
  initial begin
    int rx_gap;
    rx_gap = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        check_beat(m_tdata);
        beats_out++;
        if (beats_out == 300) rx_gap = 250;
        else if (!steady) rx_gap = pick_gap();
      end
      if (rx_gap > 0) begin
        m_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    step_row_t  row;
    route_cfg_t rc;
    int         pop_pct;

    route_shadow = '0;
    route_shadow.route_mode = MODE_ALL_SCHED;
    route_shadow.select_bit = 1;
    route_shadow.cache_enable = 1'b1;
    q_fill = '{0, 0};
    q_head = '{0, 0};
    steady = 1'b0;

    // Reset routing sends every head to the scheduler, so route flags stay 0.
    dir_steps.push_back(with_result(pop_row(1, 1), beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1)));
    dir_steps.push_back(with_result(offer_row(1, ADDR_MAX, 16'hFFFF, 0, 0, 0),
                        beat(1, 0, 1, ADDR_MAX, 16'hFFFF, 0, 0, 0, 0, 0, 0)));
    dir_steps.push_back(with_result(offer_row(0, 0, 0, 1, ADDR_MAX, 16'h1234),
                        beat(0, 0, 1, ADDR_MAX, 16'hFFFF, 0, 0, 0, 0, 0, 0)));
    dir_steps.push_back(with_result(offer_row(0, 0, 0, 1, 0, 0),
                        beat(0, 1, 1, ADDR_MAX, 16'hFFFF, 0, 1, 0, 0, 0, 0)));
    dir_steps.push_back(with_result(offer_row(1, 0, 16'h0005, 0, 0, 0),
                        beat(0, 0, 1, ADDR_MAX, 16'hFFFF, 0, 1, 0, 0, 0, 0)));
    dir_steps.push_back(offer_row(1, 48'h123, 16'hAAAA, 1, 48'h123, 16'h5555));
    dir_steps.push_back(offer_row(1, 48'h5555_5555_5555, 16'h5555,
                                  1, 48'hAAAA_AAAA_AAAA, 16'hAAAA));
    dir_steps.push_back(pop_row(1, 0));
    dir_steps.push_back(pop_row(0, 1));
    dir_steps.push_back(offer_row(0, 48'h1, 16'h1, 0, 48'h2, 16'h2));
    dir_steps.push_back(pop_row(1, 1));
    dir_steps.push_back(pop_row(1, 1));
    dir_steps.push_back(pop_row(1, 1));
    dir_steps.push_back(pop_row(0, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_steps[i]) send_beat(dir_steps[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      // The sender waits for every pending beat before touching registers.
      drain_results();
      rc = pick_routing(ph);
      apply_routing(rc);
      addr_pool[0] = rc.window_low;
      addr_pool[1] = rc.window_high;
      addr_pool[2] = rc.window_low - 1;
      addr_pool[3] = rc.window_high + 1;
      addr_pool[4] = '0;
      addr_pool[5] = ADDR_MAX;
      for (int k = 6; k < POOL_SIZE; k++) addr_pool[k] = rand_addr();
      steady = ph == 3 || ph == 7;
      pop_pct = (ph % 4 == 0) ? 10 : (ph % 4 == 1) ? 60 : (ph % 4 == 2) ? 25 : 40;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        row = '0;
        row.cmd = $urandom_range(0, 99) < pop_pct ? CMD_POP : CMD_OFFER;
        row.pair = random_pair();
        if (row.cmd == CMD_POP) begin
          row.pair.use_rd = $urandom_range(0, 99) < 70;
          row.pair.use_wr = $urandom_range(0, 99) < 70;
        end
        send_beat(row);
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d input beats and %0d output beats over %0d register settings.",
             beats_in, beats_out, PHASES + 1);
    $display("Offers refused: %0d on address hazards, %0d on full queues; %0d mismatches.",
             hazard_refusals, full_refusals, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rwhf_pkg.sv
src/rwhf_lane.sv
src/rwhf_queue.sv
src/rwhf_route.sv
src/rw_hazard_filter_queue_unit.sv
src/rwhf_checker.sv
bench/tb_top.sv
